// ===== rtl/ppes_pkg.sv =====
package ppes_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

	localparam int PID_W = 32;
	localparam int COUNT_W = 64;
	localparam int WEIGHT_W = 8;
	localparam int THR_W = 32;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CTR_WORD_W = 3 * COUNT_W;

	localparam int CYCLE_DIVISOR = 1000;
	localparam int REM_W = $clog2(CYCLE_DIVISOR);
	// divide by 1000 in 16-bit digits, two steps per digit
	localparam int DIV_DIGIT_W = 16;
	localparam int DIV_STEPS = 2 * (COUNT_W / DIV_DIGIT_W);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int TRIAL_W = REM_W + DIV_DIGIT_W;
	// 2^36/1000 rounded up gives the exact quotient for any trial below 1000*2^16
	localparam int DIV_SHIFT = TRIAL_W + REM_W;
	localparam int RECIP_W = TRIAL_W + 1;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
	localparam int DPROD_W = TRIAL_W + RECIP_W;

	localparam logic [CMD_W-1:0] EV_CYCLE = 2'd0;
	localparam logic [CMD_W-1:0] EV_MISS = 2'd1;
	localparam logic [CMD_W-1:0] EV_MISPREDICT = 2'd2;
	localparam logic [CMD_W-1:0] EV_IGNORE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MISS_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISPREDICT_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD = 2'd2;

	localparam logic [WEIGHT_W-1:0] MISS_WEIGHT_RST = 8'd7;
	localparam logic [WEIGHT_W-1:0] MISPREDICT_WEIGHT_RST = 8'd71;
	localparam logic [THR_W-1:0] SLOW_THRESHOLD_RST = 32'd10000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_CMP,
		S_MISS,
		S_UPDATE,
		S_DIV,
		S_MUL,
		S_ADD1,
		S_ADD2,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FULL,
		RES_SCORE
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     scan_next;
		logic     take_hit;
		logic     take_new;
		logic     bump;
		logic     div_start;
		logic     div_step;
		logic     mul;
		logic     add1;
		logic     add2;
		logic     emit;
		res_sel_t res_sel;
	} ctl_t;

	typedef struct packed {
		logic nop;
		logic empty;
		logic hit;
		logic last;
		logic full;
		logic score_ok;
		logic div_last;
	} status_t;

endpackage

// ===== rtl/ppes_ram.sv =====
module ppes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ppes_ctrl.sv =====
module ppes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output ppes_pkg::ctl_t    ctl,
	input  ppes_pkg::status_t st
);

	ppes_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppes_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl = '0;
		busy = 1'b1;
		unique case (state_q)
			ppes_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_nx = ppes_pkg::S_CHECK;
				end
			end
			ppes_pkg::S_CHECK: begin
				if (st.nop) begin
					ctl.emit = 1'b1;
					ctl.res_sel = ppes_pkg::RES_ZERO;
					state_nx = ppes_pkg::S_IDLE;
				end else if (st.empty) begin
					state_nx = ppes_pkg::S_MISS;
				end else begin
					state_nx = ppes_pkg::S_READ;
				end
			end
			ppes_pkg::S_READ: begin
				state_nx = ppes_pkg::S_CMP;
			end
			ppes_pkg::S_CMP: begin
				if (st.hit) begin
					ctl.take_hit = 1'b1;
					state_nx = ppes_pkg::S_UPDATE;
				end else if (st.last) begin
					state_nx = ppes_pkg::S_MISS;
				end else begin
					ctl.scan_next = 1'b1;
					state_nx = ppes_pkg::S_READ;
				end
			end
			ppes_pkg::S_MISS: begin
				if (st.full) begin
					ctl.emit = 1'b1;
					ctl.res_sel = ppes_pkg::RES_FULL;
					state_nx = ppes_pkg::S_IDLE;
				end else begin
					ctl.take_new = 1'b1;
					state_nx = ppes_pkg::S_UPDATE;
				end
			end
			ppes_pkg::S_UPDATE: begin
				ctl.bump = 1'b1;
				if (st.score_ok) begin
					ctl.div_start = 1'b1;
					state_nx = ppes_pkg::S_DIV;
				end else begin
					ctl.emit = 1'b1;
					ctl.res_sel = ppes_pkg::RES_ZERO;
					state_nx = ppes_pkg::S_IDLE;
				end
			end
			ppes_pkg::S_DIV: begin
				ctl.div_step = 1'b1;
				if (st.div_last) begin
					state_nx = ppes_pkg::S_MUL;
				end
			end
			ppes_pkg::S_MUL: begin
				ctl.mul = 1'b1;
				state_nx = ppes_pkg::S_ADD1;
			end
			ppes_pkg::S_ADD1: begin
				ctl.add1 = 1'b1;
				state_nx = ppes_pkg::S_ADD2;
			end
			ppes_pkg::S_ADD2: begin
				ctl.add2 = 1'b1;
				state_nx = ppes_pkg::S_EMIT;
			end
			ppes_pkg::S_EMIT: begin
				ctl.emit = 1'b1;
				ctl.res_sel = ppes_pkg::RES_SCORE;
				state_nx = ppes_pkg::S_IDLE;
			end
			default: begin
				state_nx = ppes_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ppes_dp.sv =====
module ppes_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [ppes_pkg::CMD_W-1:0]         cmd,
	input  logic [ppes_pkg::PID_W-1:0]         process_id,
	input  logic                               cfg_wr_en,
	input  logic [ppes_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [ppes_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  ppes_pkg::ctl_t                     ctl,
	output ppes_pkg::status_t                  st,
	output logic                               done,
	output logic                               score_valid,
	output logic [ppes_pkg::COUNT_W-1:0]       score,
	output logic                               slow_flag,
	output logic                               table_full
);

	localparam int CW = ppes_pkg::COUNT_W;

	logic [ppes_pkg::WEIGHT_W-1:0] miss_weight_q, mispredict_weight_q;
	logic [ppes_pkg::THR_W-1:0]    slow_threshold_q;

	logic [ppes_pkg::CMD_W-1:0]    cmd_q;
	logic [ppes_pkg::PID_W-1:0]    pid_q;
	logic [ppes_pkg::IDX_W-1:0]    idx_q, ent_q;
	logic [ppes_pkg::FILL_W-1:0]   fill_q;
	logic [CW-1:0]                 cyc_q, mis_q, mpr_q;
	logic [CW-1:0]                 cyc_nx, mis_nx, mpr_nx;

	logic [ppes_pkg::PID_W-1:0]      pid_rd;
	logic [ppes_pkg::CTR_WORD_W-1:0] ctr_rd;

	logic [CW-1:0]                    dvd_q;
	logic [ppes_pkg::REM_W-1:0]       rem_q;
	logic [ppes_pkg::DIV_CNT_W-1:0]   dcnt_q;
	logic [ppes_pkg::TRIAL_W-1:0]     trial;
	logic [ppes_pkg::DPROD_W-1:0]     dprod_q;
	logic [ppes_pkg::DIV_DIGIT_W-1:0] qdig;

	logic [CW-1:0] prod_m_q, prod_p_q, sum_q;

	logic          done_q, score_valid_q, slow_flag_q, table_full_q;
	logic [CW-1:0] score_q;

	// entries are never freed, so the used ones are always 0 .. fill_q-1
	ppes_ram #(
		.WIDTH(ppes_pkg::PID_W),
		.DEPTH(ppes_pkg::TABLE_ENTRIES)
	) u_pid_ram (
		.clk  (clk),
		.we   (ctl.take_new),
		.waddr(fill_q[ppes_pkg::IDX_W-1:0]),
		.wdata(pid_q),
		.raddr(idx_q),
		.rdata(pid_rd)
	);

	ppes_ram #(
		.WIDTH(ppes_pkg::CTR_WORD_W),
		.DEPTH(ppes_pkg::TABLE_ENTRIES)
	) u_ctr_ram (
		.clk  (clk),
		.we   (ctl.bump),
		.waddr(ent_q),
		.wdata({mpr_nx, mis_nx, cyc_nx}),
		.raddr(idx_q),
		.rdata(ctr_rd)
	);

	assign cyc_nx = cyc_q + CW'(cmd_q == ppes_pkg::EV_CYCLE);
	assign mis_nx = mis_q + CW'(cmd_q == ppes_pkg::EV_MISS);
	assign mpr_nx = mpr_q + CW'(cmd_q == ppes_pkg::EV_MISPREDICT);

	// long division by 1000 one 16-bit digit at a time: reciprocal multiply on even
	// steps, quotient digit and remainder on odd steps, remainder stays below 1000
	assign trial = {rem_q, dvd_q[CW-1 -: ppes_pkg::DIV_DIGIT_W]};
	assign qdig = dprod_q[ppes_pkg::DIV_SHIFT +: ppes_pkg::DIV_DIGIT_W];

	always_comb begin
		st.nop = cmd_q == ppes_pkg::EV_IGNORE;
		st.empty = fill_q == '0;
		st.hit = pid_rd == pid_q;
		st.last = (ppes_pkg::FILL_W'(idx_q) + ppes_pkg::FILL_W'(1)) == fill_q;
		st.full = fill_q == ppes_pkg::FILL_W'(ppes_pkg::TABLE_ENTRIES);
		st.score_ok = (cmd_q == ppes_pkg::EV_MISPREDICT) && (cyc_nx != '0) &&
			(mis_nx != '0) && (mpr_nx != '0);
		st.div_last = dcnt_q == ppes_pkg::DIV_CNT_W'(ppes_pkg::DIV_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_weight_q <= ppes_pkg::MISS_WEIGHT_RST;
			mispredict_weight_q <= ppes_pkg::MISPREDICT_WEIGHT_RST;
			slow_threshold_q <= ppes_pkg::SLOW_THRESHOLD_RST;
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					ppes_pkg::CFG_MISS_WEIGHT: begin
						miss_weight_q <= cfg_wdata[ppes_pkg::WEIGHT_W-1:0];
					end
					ppes_pkg::CFG_MISPREDICT_WEIGHT: begin
						mispredict_weight_q <= cfg_wdata[ppes_pkg::WEIGHT_W-1:0];
					end
					ppes_pkg::CFG_SLOW_THRESHOLD: begin
						slow_threshold_q <= cfg_wdata[ppes_pkg::THR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (ctl.take_new) begin
				fill_q <= fill_q + ppes_pkg::FILL_W'(1);
			end
			done_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			pid_q <= process_id;
			idx_q <= '0;
		end else if (ctl.scan_next) begin
			idx_q <= idx_q + ppes_pkg::IDX_W'(1);
		end

		if (ctl.take_hit) begin
			ent_q <= idx_q;
			cyc_q <= ctr_rd[CW-1:0];
			mis_q <= ctr_rd[2*CW-1:CW];
			mpr_q <= ctr_rd[3*CW-1:2*CW];
		end else if (ctl.take_new) begin
			ent_q <= fill_q[ppes_pkg::IDX_W-1:0];
			cyc_q <= '0;
			mis_q <= '0;
			mpr_q <= '0;
		end else if (ctl.bump) begin
			cyc_q <= cyc_nx;
			mis_q <= mis_nx;
			mpr_q <= mpr_nx;
		end

		if (ctl.div_start) begin
			dvd_q <= cyc_nx;
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (ctl.div_step) begin
			if (!dcnt_q[0]) begin
				dprod_q <= ppes_pkg::DPROD_W'(trial) * ppes_pkg::DPROD_W'(ppes_pkg::DIV_RECIP);
			end else begin
				dvd_q <= {dvd_q[CW-ppes_pkg::DIV_DIGIT_W-1:0], qdig};
				rem_q <= ppes_pkg::REM_W'(trial - ppes_pkg::TRIAL_W'(qdig) *
					ppes_pkg::TRIAL_W'(ppes_pkg::CYCLE_DIVISOR));
			end
			dcnt_q <= dcnt_q + ppes_pkg::DIV_CNT_W'(1);
		end

		if (ctl.mul) begin
			prod_m_q <= mis_q * CW'(miss_weight_q);
			prod_p_q <= mpr_q * CW'(mispredict_weight_q);
		end

		if (ctl.add1) begin
			sum_q <= dvd_q + prod_m_q;
		end else if (ctl.add2) begin
			sum_q <= sum_q + prod_p_q;
		end

		if (ctl.emit) begin
			unique case (ctl.res_sel)
				ppes_pkg::RES_SCORE: begin
					score_valid_q <= 1'b1;
					score_q <= sum_q;
					slow_flag_q <= sum_q > CW'(slow_threshold_q);
					table_full_q <= 1'b0;
				end
				ppes_pkg::RES_FULL: begin
					score_valid_q <= 1'b0;
					score_q <= '0;
					slow_flag_q <= 1'b0;
					table_full_q <= 1'b1;
				end
				default: begin
					score_valid_q <= 1'b0;
					score_q <= '0;
					slow_flag_q <= 1'b0;
					table_full_q <= 1'b0;
				end
			endcase
		end
	end

	assign done = done_q;
	assign score_valid = score_valid_q;
	assign score = score_q;
	assign slow_flag = slow_flag_q;
	assign table_full = table_full_q;

endmodule

// ===== rtl/per_process_event_score_table_unit.sv =====
// from start taken to the done beat: an ignored command ends in the check state; each entry
// compared takes a read and a compare state via the id ram port; a hit ends in update, a
// dropped event in miss, a new entry passes both; a score adds an eight-step divide by 1000
// in 16-bit digits, products, two 64-bit adds; a dropped event compares all 64 entries
// throughput: one event at a time; a new start is taken in the cycle done is high
// reset (arst_n low, async) empties the table via its fill count, restores register defaults
module per_process_event_score_table_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ppes_pkg::CMD_W-1:0]         cmd,
	input  logic [ppes_pkg::PID_W-1:0]         process_id,
	input  logic                               cfg_wr_en,
	input  logic [ppes_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [ppes_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                               done,
	output logic                               score_valid,
	output logic [ppes_pkg::COUNT_W-1:0]       score,
	output logic                               slow_flag,
	output logic                               table_full
);

	ppes_pkg::ctl_t    ctl;
	ppes_pkg::status_t st;

	ppes_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.ctl   (ctl),
		.st    (st)
	);

	ppes_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.process_id (process_id),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.ctl        (ctl),
		.st         (st),
		.done       (done),
		.score_valid(score_valid),
		.score      (score),
		.slow_flag  (slow_flag),
		.table_full (table_full)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("start taken but block not busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in progress");

	a_score_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !score_valid |-> score == '0)
		else $error("score nonzero without a valid score");

	a_slow_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done && slow_flag |-> score_valid)
		else $error("slow flag without a valid score");

	a_full_no_score: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !score_valid)
		else $error("score given for a dropped event");

endmodule
